// File: sv/arpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants for the ARP cache table
// Request codes, the request record handed from cell to cell, and defaults.
// ----------------------------------------------------------------------------
package arpc_pkg;

	// Default table depth
	localparam int ENTRIES_DEF = 128;

	// Request kinds
	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;

	// Configuration register map (byte address bit 2 selects the register)
	localparam int          PADDR_W     = 3;
	localparam logic        REG_TIMEOUT = 1'b0;
	localparam logic [15:0] TIMEOUT_RST = 16'd15;

	// Request record moving along the cell chain
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] ip_addr;
		logic [47:0] mac_addr;
		logic [31:0] sec;        // second count seen by this request
		logic        hit;
		logic [47:0] found_mac;
		logic        stored;
	} req_t;

endpackage
`default_nettype wire

// File: sv/arpc_apb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_apb: configuration register slave
// Holds the aging timeout; writes on the access phase, zero-wait reads.
// ----------------------------------------------------------------------------
module arpc_apb (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [arpc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output logic [15:0]                      timeout
);
	import arpc_pkg::*;

	logic [15:0] timeout_q;
	logic        wr_en;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign timeout = timeout_q;

	// Timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (wr_en && (paddr[2] == REG_TIMEOUT)) begin
			timeout_q <= pwdata[15:0];
		end
	end

	// Read mux
	always_comb begin
		if (paddr[2] == REG_TIMEOUT) begin
			prdata = {16'd0, timeout_q};
		end else begin
			prdata = 32'd0;
		end
	end

endmodule
`default_nettype wire

// File: sv/arpc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_cell: one table entry plus one stage of the request chain
// Applies the passing request to its entry and forwards it to the next cell.
// ----------------------------------------------------------------------------
module arpc_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire logic [15:0]    timeout,
	input  wire logic           in_valid,
	input  wire arpc_pkg::req_t in_req,
	output logic                out_valid,
	output arpc_pkg::req_t      out_req
);
	import arpc_pkg::*;

	// Entry storage
	logic        valid_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic [31:0] stamp_q;

	// Chain stage
	logic        valid_s1;
	req_t        req_s1;

	req_t        req_nxt;
	logic [31:0] age;
	logic        match;
	logic        do_write;
	logic        do_expire;

	assign age   = in_req.sec - stamp_q;
	assign match = valid_q && (ip_q == in_req.ip_addr);

	// Per-entry decision for the passing request
	always_comb begin
		req_nxt   = in_req;
		do_write  = 1'b0;
		do_expire = 1'b0;
		unique case (in_req.kind)
			KIND_LOOKUP: begin
				// later entries override: highest index wins
				if (match) begin
					req_nxt.hit       = 1'b1;
					req_nxt.found_mac = mac_q;
				end
			end
			KIND_INSERT: begin
				// first free slot takes the entry
				if (!valid_q && !in_req.stored) begin
					do_write       = 1'b1;
					req_nxt.stored = 1'b1;
				end
			end
			KIND_TICK: begin
				do_expire = valid_q && (age > {16'd0, timeout});
			end
			default: begin
			end
		endcase
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv && in_valid) begin
			if (do_write) begin
				valid_q <= 1'b1;
			end else if (do_expire) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		if (adv && in_valid && do_write) begin
			ip_q    <= in_req.ip_addr;
			mac_q   <= in_req.mac_addr;
			stamp_q <= in_req.sec;
		end
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= req_nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_req   = req_s1;

endmodule
`default_nettype wire

// File: sv/arp_cache_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a request passes through the registered stage of every table cell in turn,
//   the last cell's stage being the output register.
// Throughput: one request per cycle; the whole cell chain holds while a result
//   waits on out_stall.
// Reset: all entries invalid and the second count zero at once; no clearing pass.
// ----------------------------------------------------------------------------
// arp_cache_table_core: IPv4-to-MAC table with lookup, insert and aging
// Requests walk a chain of entry cells that each apply them to one entry.
// ----------------------------------------------------------------------------
module arp_cache_table_core #(
	parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   kind,
	input  wire logic [31:0]                  ip_addr,
	input  wire logic [47:0]                  mac_addr,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              hit,
	output logic [47:0]                       found_mac,
	output logic                              stored,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [arpc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import arpc_pkg::*;

	logic [15:0] timeout;
	logic        adv;
	logic        accept;
	logic [31:0] seconds_q;
	logic [31:0] sec_req;

	logic        chain_valid [ENTRIES+1];
	req_t        chain_req   [ENTRIES+1];

	// Configuration registers
	arpc_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.timeout (timeout)
	);

	// Chain moves unless a finished result is held
	assign adv      = !chain_valid[ENTRIES] || !out_stall;
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	// Second counter; a tick carries the advanced count
	assign sec_req = (kind == KIND_TICK) ? seconds_q + 32'd1 : seconds_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seconds_q <= 32'd0;
		end else if (accept && (kind == KIND_TICK)) begin
			seconds_q <= sec_req;
		end
	end

	// Request entering the first cell
	assign chain_valid[0]         = in_valid;
	assign chain_req[0].kind      = kind;
	assign chain_req[0].ip_addr   = ip_addr;
	assign chain_req[0].mac_addr  = mac_addr;
	assign chain_req[0].sec       = sec_req;
	assign chain_req[0].hit       = 1'b0;
	assign chain_req[0].found_mac = 48'd0;
	assign chain_req[0].stored    = 1'b0;

	// Row of entry cells, index 0 first
	for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
		arpc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.timeout   (timeout),
			.in_valid  (chain_valid[gi]),
			.in_req    (chain_req[gi]),
			.out_valid (chain_valid[gi+1]),
			.out_req   (chain_req[gi+1])
		);
	end

	// Result from the last cell's stage
	assign out_valid = chain_valid[ENTRIES];
	assign hit       = chain_req[ENTRIES].hit;
	assign found_mac = chain_req[ENTRIES].found_mac;
	assign stored    = chain_req[ENTRIES].stored;

endmodule
`default_nettype wire
